@@ sv/vlfp_pkg.sv @@
// shared types and constants of the varint length frame parser
package vlfp_pkg;

  localparam int LENGTH_BITS_DEFAULT = 24;
  localparam int CFG_W = 24;
  localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 24'd65536;
  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
  localparam int BYTE_W = 8;
  localparam int LEN_OUT_W = 24;

  typedef enum logic [2:0] {
    PH_LENGTH  = 3'b001,
    PH_TYPE    = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_VARINT = 2'd1,
    FAULT_LIMIT  = 2'd2
  } fault_t;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] payload_length;
    logic [BYTE_W-1:0]    message_type;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 first_of_message;
    logic                 last_of_message;
    logic                 empty_message;
    fault_t               fault_code;
  } res_t;

endpackage

@@ sv/vlfp_out_buf.sv @@
// two-entry output register with skid stage for result beats
module vlfp_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vlfp_pkg::res_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output vlfp_pkg::res_t out_data
);

  logic           skid_valid;
  vlfp_pkg::res_t skid_data;
  logic           pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ sv/varint_length_frame_parser_core.sv @@
// top level of the varint length frame parser
// Parses a framed byte stream: each message is an unsigned LEB128 length
// (type byte plus payload), a type byte, then the payload. One stream byte is
// taken every clock while the skid stage is empty, and the parse state is
// registered. Each result beat is registered in the output register, or in
// the skid stage when that register is held, so s_axis_tready comes from a
// flop and stays high as long as the sink drains. Faults (varint over ten
// bytes, zero or over-limit length) give one fault beat, then all input
// bytes are swallowed until reset.
module varint_length_frame_parser_core #(
  parameter int LENGTH_BITS = vlfp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // payload_byte, message_type, payload_length
  output logic        m_axis_tlast,   // last_of_message
  output logic [3:0]  m_axis_tuser,   // first_of_message, empty_message, fault_code
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata       // max_payload
);

  localparam int ACC_W = LENGTH_BITS + 1;
  localparam int SH_W  = ACC_W + 7;
  localparam int CMP_W = (ACC_W > vlfp_pkg::CFG_W + 1) ? ACC_W : vlfp_pkg::CFG_W + 1;
  localparam logic [CMP_W-1:0] CAP = CMP_W'((64'd1 << LENGTH_BITS) - 64'd1);

  vlfp_pkg::phase_t          phase, phase_next;
  logic [ACC_W-1:0]          accum, accum_next;
  logic                      overflow, overflow_next;
  logic [3:0]                count, count_next;
  logic [LENGTH_BITS-1:0]    remaining, remaining_next;
  logic [7:0]                held_type, held_type_next;
  logic                      sticky, sticky_next;
  logic [vlfp_pkg::CFG_W-1:0] max_payload;

  logic                      accept;
  logic                      emit;
  vlfp_pkg::res_t            res;
  vlfp_pkg::res_t            out_res;
  logic                      space;

  logic [6:0]                shift;
  logic [SH_W-1:0]           shifted;
  logic [ACC_W-1:0]          acc_upd;
  logic                      ovf_upd;
  logic [CMP_W-1:0]          limit;
  logic [CMP_W-1:0]          acc_ext;
  logic [CMP_W-1:0]          len_ext;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // varint digit placement
  assign shift   = 7'(count) * 7'd7;
  assign shifted = SH_W'(s_axis_tdata[6:0]) << shift;

  always_comb begin
    if (shift >= 7'(ACC_W)) begin
      acc_upd = accum;
      ovf_upd = overflow || (s_axis_tdata[6:0] != 7'd0);
    end else begin
      acc_upd = accum | shifted[ACC_W-1:0];
      ovf_upd = overflow || (shifted[SH_W-1:ACC_W] != 7'd0);
    end
  end

  assign limit   = (CMP_W'(max_payload) > CAP) ? CAP : CMP_W'(max_payload);
  assign acc_ext = CMP_W'(acc_upd);
  assign len_ext = CMP_W'(accum);

  always_comb begin
    phase_next     = phase;
    accum_next     = accum;
    overflow_next  = overflow;
    count_next     = count;
    remaining_next = remaining;
    held_type_next = held_type;
    sticky_next    = sticky;
    emit           = 1'b0;
    res            = '0;
    res.fault_code = vlfp_pkg::FAULT_NONE;
    if (accept && !sticky) begin
      case (phase)
        vlfp_pkg::PH_TYPE: begin
          held_type_next = s_axis_tdata;
          if (accum == '0) begin
            emit                 = 1'b1;
            res.message_type     = s_axis_tdata;
            res.first_of_message = 1'b1;
            res.last_of_message  = 1'b1;
            res.empty_message    = 1'b1;
            phase_next           = vlfp_pkg::PH_LENGTH;
            accum_next           = '0;
            overflow_next        = 1'b0;
            count_next           = '0;
          end else begin
            remaining_next = accum[LENGTH_BITS-1:0];
            phase_next     = vlfp_pkg::PH_PAYLOAD;
          end
        end
        vlfp_pkg::PH_PAYLOAD: begin
          emit                 = 1'b1;
          res.payload_byte     = s_axis_tdata;
          res.message_type     = held_type;
          res.payload_length   = len_ext[vlfp_pkg::LEN_OUT_W-1:0];
          res.first_of_message = (ACC_W'(remaining) == accum);
          res.last_of_message  = (remaining <= LENGTH_BITS'(1));
          if (remaining <= LENGTH_BITS'(1)) begin
            remaining_next = '0;
            phase_next     = vlfp_pkg::PH_LENGTH;
            accum_next     = '0;
            overflow_next  = 1'b0;
            count_next     = '0;
          end else begin
            remaining_next = remaining - LENGTH_BITS'(1);
          end
        end
        default: begin
          phase_next = vlfp_pkg::PH_LENGTH;
          if (count >= vlfp_pkg::VARINT_MAX_BYTES) begin
            emit           = 1'b1;
            res.fault_code = vlfp_pkg::FAULT_VARINT;
            sticky_next    = 1'b1;
            accum_next     = '0;
            overflow_next  = 1'b0;
            count_next     = '0;
          end else if (s_axis_tdata[7]) begin
            accum_next    = acc_upd;
            overflow_next = ovf_upd;
            count_next    = count + 4'd1;
          end else if (ovf_upd || acc_upd == '0 || acc_ext > limit + CMP_W'(1)) begin
            emit           = 1'b1;
            res.fault_code = vlfp_pkg::FAULT_LIMIT;
            sticky_next    = 1'b1;
            accum_next     = '0;
            overflow_next  = 1'b0;
            count_next     = '0;
          end else begin
            accum_next    = acc_upd - ACC_W'(1);
            overflow_next = ovf_upd;
            count_next    = '0;
            phase_next    = vlfp_pkg::PH_TYPE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= vlfp_pkg::PH_LENGTH;
      accum       <= '0;
      overflow    <= 1'b0;
      count       <= '0;
      remaining   <= '0;
      held_type   <= '0;
      sticky      <= 1'b0;
      max_payload <= vlfp_pkg::MAX_PAYLOAD_RESET;
    end else begin
      phase     <= phase_next;
      accum     <= accum_next;
      overflow  <= overflow_next;
      count     <= count_next;
      remaining <= remaining_next;
      held_type <= held_type_next;
      sticky    <= sticky_next;
      if (cfg_we) begin
        max_payload <= cfg_wdata;
      end
    end
  end

  vlfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (res),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {out_res.payload_length, out_res.message_type, out_res.payload_byte};
  assign m_axis_tlast = out_res.last_of_message;
  assign m_axis_tuser = {out_res.fault_code, out_res.empty_message, out_res.first_of_message};

endmodule

@@ sv/vlfp_checker.sv @@
// port-level checks for the varint length frame parser
module vlfp_assertions (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [3:0]  m_axis_tuser
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat after reset");

  // fault beat carries nothing but the code
  a_fault_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[3:2] != 2'd0) |->
      (m_axis_tdata == 40'd0 && !m_axis_tlast && m_axis_tuser[1:0] == 2'b00))
    else $error("fault beat with nonzero fields");

  // empty message is a single first and last beat with no data
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tuser[0] && m_axis_tlast && m_axis_tdata[7:0] == 8'd0 &&
       m_axis_tdata[39:16] == 24'd0))
    else $error("malformed empty beat");

  // nothing follows a delivered fault beat
  a_fault_final: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser[3:2] != 2'd0) |=> !m_axis_tvalid)
    else $error("beat after fault");

endmodule

bind varint_length_frame_parser_core vlfp_assertions u_vlfp_assertions (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
